/* hdl/grid_ray_cast_column_defines.svh */
// Assertion helpers for the ray caster. Each expects clk and arst_n in scope.
`ifndef GRID_RAY_CAST_COLUMN_DEFINES_SVH
`define GRID_RAY_CAST_COLUMN_DEFINES_SVH

// same-cycle implication
`define GRC_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRC_CHECK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/grc_pkg.sv */
`default_nettype none
package grc_pkg;

	localparam int TILE_W  = 3;
	localparam int POS_W   = 16;
	localparam int DIR_W   = 16;
	localparam int PERP_W  = 24;
	localparam int ROWPX_W = 12;
	localparam int FOG_W   = 16;
	localparam int COL_W   = 8;
	localparam int DD_W    = 41;   // delta distance, Q16 tiles, up to 2^40
	localparam int SD_W    = 52;   // accumulated side distance
	localparam int CELL_W  = 10;   // signed map coordinate during the walk
	localparam int DVD_W   = 32;
	localparam int DSR_W   = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOG_DISTANCE = 1'd1;

	localparam logic [ROWPX_W-1:0] VIEW_HEIGHT_RST  = 12'd720;
	localparam logic [FOG_W-1:0]   FOG_DISTANCE_RST = 16'd3072;
	localparam logic [DD_W-1:0]    FAR_DELTA = {1'b1, 40'd0};
	localparam logic [PERP_W-1:0]  MIN_PERP  = 24'd7;
	localparam logic [DVD_W-1:0]   DELTA_NUM = 32'h4000_0000;

	typedef struct packed {
		logic                     action;
		logic [4:0]               cell_row;
		logic [4:0]               cell_col;
		logic [TILE_W-1:0]        tile_value;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic signed [DIR_W-1:0]  ray_dir_x;
		logic signed [DIR_W-1:0]  ray_dir_y;
	} ray_t;

	typedef struct packed {
		logic [PERP_W-1:0]  perp_dist;
		logic [TILE_W-1:0]  wall_code;
		logic               hit_vertical_side;
		logic [POS_W-1:0]   hit_x;
		logic [POS_W-1:0]   hit_y;
		logic               found;
		logic [ROWPX_W-1:0] strip_top;
		logic [ROWPX_W-1:0] strip_bottom;
		logic [COL_W-1:0]   red;
		logic [COL_W-1:0]   green;
		logic [COL_W-1:0]   blue;
	} hit_t;

	typedef enum logic [2:0] {
		DIV_DX    = 3'd0,
		DIV_DY    = 3'd1,
		DIV_HGT   = 3'd2,
		DIV_RED   = 3'd3,
		DIV_GREEN = 3'd4,
		DIV_BLUE  = 3'd5
	} div_op_t;

	typedef struct packed {
		logic    clear;
		logic    write;
		logic    load;
		logic    div_start;
		logic    div_store;
		div_op_t div_op;
		logic    side;
		logic    step;
		logic    test;
		logic    perp;
		logic    along;
		logic    hit;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic div_done;
		logic wall;
		logic steps_done;
		logic out_free;
	} status_t;

	// palette as {r, g, b}
	function automatic logic [3*COL_W-1:0] palette(input logic [TILE_W-1:0] tile);
		logic [3*COL_W-1:0] c;
		case (tile)
			3'd1:    c = {8'd169, 8'd169, 8'd169};
			3'd2:    c = {8'd255, 8'd0, 8'd0};
			3'd3:    c = {8'd0, 8'd0, 8'd255};
			3'd4:    c = {8'd0, 8'd255, 8'd0};
			3'd5:    c = {8'd255, 8'd0, 8'd255};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/grc_if.sv */
`default_nettype none
interface grc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hdl/grid_ray_cast_column.sv */
`default_nettype none
// Grid ray caster for one screen column. The ray channel carries two kinds of item:
// action 0 writes one tile code into the MAP_ROWS x MAP_COLS map (no result; cells
// outside the map are dropped), action 1 casts one ray and yields one item on the
// hit channel with distance, hit point, side, tile, found flag, wall strip rows
// and fog-dimmed colour. Cells outside the map read as tile 1. A cast walks 1 to
// MAX_STEPS grid cells and makes six passes through one shared radix-2 divider
// (start, 32 quotient bits, store; two deltas, strip height, three colour
// channels); each step reads the map and then tests the cell, and single states
// handle side setup, distance, hit point and output load. No new item is taken
// before a cast's result has been loaded into the output register.
// One item is in work at a time; a finished result sits in an output register so
// the next item is taken while it waits. After reset the map is zeroed by a
// clearing pass over all 2^(clog2(MAP_ROWS)+clog2(MAP_COLS)) cells (1024 by default),
// during which no item is accepted; configuration writes are taken at any time.
// cfg_index 0 is view_height, 1 is fog_distance.
module grid_ray_cast_column #(
	parameter int MAP_ROWS  = 32,
	parameter int MAP_COLS  = 32,
	parameter int MAX_STEPS = 100
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	grc_if.sink                                  ray,
	grc_if.source                                hit,
	input  wire logic                            cfg_we,
	input  wire logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [grc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import grc_pkg::*;

	logic [ROWPX_W-1:0] view_height_q;
	logic [FOG_W-1:0]   fog_distance_q;
	cmd_t               cmd;
	status_t            status;
	ray_t               ray_item;
	hit_t               hit_item;
	logic               hit_valid;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_height_q  <= VIEW_HEIGHT_RST;
			fog_distance_q <= FOG_DISTANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEW_HEIGHT:  view_height_q  <= cfg_data[ROWPX_W-1:0];
				CFG_FOG_DISTANCE: fog_distance_q <= cfg_data;
				default:          fog_distance_q <= fog_distance_q;
			endcase
		end
	end

	assign ray_item = ray.payload;

	grc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ray_valid (ray.valid),
		.ray_cast  (ray_item.action),
		.ray_ready (ray.ready),
		.status    (status),
		.cmd       (cmd)
	);

	grc_dp #(
		.MAP_ROWS  (MAP_ROWS),
		.MAP_COLS  (MAP_COLS),
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.ray_in       (ray_item),
		.view_height  (view_height_q),
		.fog_distance (fog_distance_q),
		.out_ready    (hit.ready),
		.out_valid    (hit_valid),
		.out_item     (hit_item)
	);

	// result register drives the hit channel directly
	assign hit.valid   = hit_valid;
	assign hit.payload = hit_item;

endmodule
`default_nettype wire

/* hdl/grc_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module grc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [grc_pkg::DVD_W-1:0]   dividend,
	input  wire logic [grc_pkg::DSR_W-1:0]   divisor,
	output logic                             done,
	output logic [grc_pkg::DVD_W-1:0]        quotient
);
	import grc_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

/* hdl/grc_ctrl.sv */
`default_nettype none
module grc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              ray_valid,
	input  wire logic              ray_cast,
	output logic                   ray_ready,
	input  wire grc_pkg::status_t  status,
	output grc_pkg::cmd_t          cmd
);
	import grc_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR     = 11'b00000000001,
		S_IDLE      = 11'b00000000010,
		S_DIV_START = 11'b00000000100,
		S_DIV_WAIT  = 11'b00000001000,
		S_SIDE      = 11'b00000010000,
		S_STEP      = 11'b00000100000,
		S_TEST      = 11'b00001000000,
		S_PERP      = 11'b00010000000,
		S_ALONG     = 11'b00100000000,
		S_HIT       = 11'b01000000000,
		S_OUT       = 11'b10000000000
	} state_t;

	state_t  state_q, state_d;
	div_op_t op_q, op_d;
	logic    accept;

	assign ray_ready = (state_q == S_IDLE);
	assign accept    = ray_valid && ray_ready;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.div_op = op_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (ray_cast) begin
						cmd.load = 1'b1;
						op_d     = DIV_DX;
						state_d  = S_DIV_START;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_store = 1'b1;
					unique case (op_q)
						DIV_DX:    begin op_d = DIV_DY;    state_d = S_DIV_START; end
						DIV_DY:    state_d = S_SIDE;
						DIV_HGT:   begin op_d = DIV_RED;   state_d = S_DIV_START; end
						DIV_RED:   begin op_d = DIV_GREEN; state_d = S_DIV_START; end
						DIV_GREEN: begin op_d = DIV_BLUE;  state_d = S_DIV_START; end
						DIV_BLUE:  state_d = S_OUT;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_SIDE: begin
				cmd.side = 1'b1;
				state_d  = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_TEST;
			end
			S_TEST: begin
				cmd.test = 1'b1;
				if (status.wall || status.steps_done) state_d = S_PERP;
				else state_d = S_STEP;
			end
			S_PERP: begin
				cmd.perp = 1'b1;
				state_d  = S_ALONG;
			end
			S_ALONG: begin
				cmd.along = 1'b1;
				state_d   = S_HIT;
			end
			S_HIT: begin
				cmd.hit = 1'b1;
				op_d    = DIV_HGT;
				state_d = S_DIV_START;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q    <= DIV_DX;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/grc_dp.sv */
`default_nettype none
module grc_dp #(
	parameter int MAP_ROWS  = 32,
	parameter int MAP_COLS  = 32,
	parameter int MAX_STEPS = 100
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire grc_pkg::cmd_t                 cmd,
	output grc_pkg::status_t                   status,
	input  wire grc_pkg::ray_t                 ray_in,
	input  wire logic [grc_pkg::ROWPX_W-1:0]   view_height,
	input  wire logic [grc_pkg::FOG_W-1:0]     fog_distance,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output grc_pkg::hit_t                      out_item
);
	import grc_pkg::*;

	localparam int RW    = $clog2(MAP_ROWS);
	localparam int CW    = $clog2(MAP_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int SW    = $clog2(MAX_STEPS + 1);

	logic [TILE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_addr_q;
	logic [TILE_W-1:0] rd_data_q;

	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q;
	logic [DD_W-1:0]         ddx_q, ddy_q;
	logic [SD_W-1:0]         sdx_q, sdy_q;
	logic signed [CELL_W-1:0] mx_q, my_q;
	logic                    xside_q;
	logic [SW-1:0]           cnt_q;
	logic [TILE_W-1:0]       tile_q;
	logic                    found_q;
	logic [PERP_W-1:0]       perp_q;
	logic signed [40:0]      prod_q;
	logic [POS_W-1:0]        hit_x_q, hit_y_q;
	logic [ROWPX_W-1:0]      ds_q, de_q;
	logic [COL_W-1:0]        red_q, green_q, blue_q;
	logic                    out_valid_q;
	hit_t                    out_q;

	// divider
	logic             div_done;
	logic [DVD_W-1:0] quot;
	logic [DVD_W-1:0] dvd;
	logic [DSR_W-1:0] dsr;

	// map write decode
	logic [8:0]    row9, col9;
	logic          wr_in_map;
	logic [AW-1:0] wr_addr;

	assign row9      = {4'b0, ray_in.cell_row};
	assign col9      = {4'b0, ray_in.cell_col};
	assign wr_in_map = (row9 < 9'(MAP_ROWS)) && (col9 < 9'(MAP_COLS));
	assign wr_addr   = {row9[RW-1:0], col9[CW-1:0]};

	// direction terms
	logic             sx, sy;
	logic [DIR_W-1:0] mag_x, mag_y;
	logic             far_x, far_y;
	logic [11:0]      frac_x, frac_y;
	logic [41:0]      mul_x, mul_y;
	logic [SD_W-1:0]  side_x, side_y;

	assign sx     = !dir_x_q[DIR_W-1];
	assign sy     = !dir_y_q[DIR_W-1];
	assign mag_x  = dir_x_q[DIR_W-1] ? (~dir_x_q + 16'sd1) : dir_x_q;
	assign mag_y  = dir_y_q[DIR_W-1] ? (~dir_y_q + 16'sd1) : dir_y_q;
	assign far_x  = mag_x <= 16'd1;
	assign far_y  = mag_y <= 16'd1;
	assign frac_x = sx ? (12'd2048 - {1'b0, pos_x_q[10:0]}) : {1'b0, pos_x_q[10:0]};
	assign frac_y = sy ? (12'd2048 - {1'b0, pos_y_q[10:0]}) : {1'b0, pos_y_q[10:0]};
	assign mul_x  = {30'b0, frac_x} * {12'b0, ddx_q[29:0]};
	assign mul_y  = {30'b0, frac_y} * {12'b0, ddy_q[29:0]};
	assign side_x = far_x ? SD_W'({frac_x, 29'b0}) : SD_W'(mul_x[41:11]);
	assign side_y = far_y ? SD_W'({frac_y, 29'b0}) : SD_W'(mul_y[41:11]);

	// one DDA step
	logic                     x_first;
	logic signed [CELL_W-1:0] mx_nx, my_nx;
	logic [AW-1:0]            rd_addr;
	logic                     oob;

	assign x_first = sdx_q < sdy_q;
	assign mx_nx   = !x_first ? mx_q : (sx ? mx_q + 10'sd1 : mx_q - 10'sd1);
	assign my_nx   = x_first ? my_q : (sy ? my_q + 10'sd1 : my_q - 10'sd1);
	assign rd_addr = {my_nx[RW-1:0], mx_nx[CW-1:0]};
	assign oob     = mx_q[CELL_W-1] || (mx_q >= CELL_W'(MAP_COLS)) ||
	                 my_q[CELL_W-1] || (my_q >= CELL_W'(MAP_ROWS));

	// distance and hit point
	logic [SD_W-1:0]    raw;
	logic [PERP_W-1:0]  perp_sat;
	logic [PERP_W-1:0]  pc;
	logic [POS_W-1:0]   along_pos, along_c, line_c;
	logic [23:0]        along_sum;
	logic [CELL_W-1:0]  line_t;

	assign raw      = xside_q ? (sdx_q - SD_W'(ddx_q)) : (sdy_q - SD_W'(ddy_q));
	assign perp_sat = (|raw[SD_W-1:PERP_W]) ? '1 : raw[PERP_W-1:0];
	assign pc       = (perp_q < MIN_PERP) ? MIN_PERP : perp_q;

	assign along_pos = xside_q ? pos_y_q : pos_x_q;
	assign along_sum = {8'b0, along_pos} + {{2{prod_q[40]}}, prod_q[40:19]};
	assign along_c   = along_sum[23] ? '0 : ((|along_sum[22:16]) ? '1 : along_sum[15:0]);

	assign line_t = xside_q ? (sx ? mx_q : mx_q + 10'sd1) : (sy ? my_q : my_q + 10'sd1);
	assign line_c = line_t[CELL_W-1] ? '0 :
	                ((|line_t[CELL_W-2:5]) ? '1 : {line_t[4:0], 11'b0});

	// strip and fog operands
	logic [ROWPX_W-1:0] hgt;
	logic [PERP_W-1:0]  fq;
	logic [PERP_W-1:0]  fog_gap;
	logic [3*COL_W-1:0] pal;
	logic [COL_W-1:0]   base;
	logic [DVD_W-1:0]   col_dvd;
	logic [30:0]        half_h;
	logic [10:0]        half_v;
	logic [31:0]        de_sum;

	assign hgt     = (view_height == '0) ? 12'd1 : view_height;
	assign fq      = {((fog_distance == '0) ? 16'd1 : fog_distance), 8'b0};
	assign fog_gap = fq - pc;
	assign pal     = palette(tile_q);

	always_comb begin
		case (cmd.div_op)
			DIV_RED:   base = pal[23:16];
			DIV_GREEN: base = pal[15:8];
			default:   base = pal[7:0];
		endcase
	end

	assign col_dvd = (pc >= fq) ? '0 : ({24'b0, base} * {8'b0, fog_gap});

	always_comb begin
		unique case (cmd.div_op)
			DIV_DX:  begin dvd = DELTA_NUM; dsr = {8'b0, mag_x}; end
			DIV_DY:  begin dvd = DELTA_NUM; dsr = {8'b0, mag_y}; end
			DIV_HGT: begin dvd = {4'b0, hgt, 16'b0}; dsr = pc; end
			default: begin dvd = col_dvd; dsr = fq; end
		endcase
	end

	assign half_h = quot[31:1];
	assign half_v = hgt[11:1];
	assign de_sum = {1'b0, half_h} + {21'b0, half_v};

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dsr),
		.done     (div_done),
		.quotient (quot)
	);

	// map memory: clearing pass, cell writes, walk reads
	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_addr_q] <= '0;
		else if (cmd.write && wr_in_map) mem[wr_addr] <= ray_in.tile_value;
		if (cmd.step) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q <= ray_in.pos_x;
			pos_y_q <= ray_in.pos_y;
			dir_x_q <= ray_in.ray_dir_x;
			dir_y_q <= ray_in.ray_dir_y;
			mx_q    <= CELL_W'(ray_in.pos_x[15:11]);
			my_q    <= CELL_W'(ray_in.pos_y[15:11]);
			xside_q <= 1'b1;
			found_q <= 1'b0;
			tile_q  <= '0;
		end
		if (cmd.div_store) begin
			unique case (cmd.div_op)
				DIV_DX:  ddx_q <= far_x ? FAR_DELTA : {11'b0, quot[29:0]};
				DIV_DY:  ddy_q <= far_y ? FAR_DELTA : {11'b0, quot[29:0]};
				DIV_HGT: begin
					ds_q <= (half_h >= {20'b0, half_v}) ? '0
					        : {1'b0, half_v - half_h[10:0]};
					de_q <= (de_sum >= {20'b0, hgt}) ? (hgt - 12'd1) : de_sum[11:0];
				end
				DIV_RED:   red_q   <= quot[7:0];
				DIV_GREEN: green_q <= quot[7:0];
				DIV_BLUE:  blue_q  <= quot[7:0];
				default:   blue_q  <= quot[7:0];
			endcase
		end
		if (cmd.side) begin
			sdx_q <= side_x;
			sdy_q <= side_y;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			if (x_first) sdx_q <= sdx_q + SD_W'(ddx_q);
			else sdy_q <= sdy_q + SD_W'(ddy_q);
			mx_q    <= mx_nx;
			my_q    <= my_nx;
			xside_q <= x_first;
			cnt_q   <= cnt_q + 1'b1;
		end
		if (cmd.test) begin
			found_q <= status.wall;
			tile_q  <= oob ? TILE_W'(1) : rd_data_q;
		end
		if (cmd.perp) perp_q <= perp_sat;
		if (cmd.along) prod_q <= $signed({1'b0, perp_q}) * (xside_q ? dir_y_q : dir_x_q);
		if (cmd.hit) begin
			hit_x_q <= xside_q ? line_c : along_c;
			hit_y_q <= xside_q ? along_c : line_c;
		end
		if (cmd.out_load) begin
			out_q.perp_dist         <= perp_q;
			out_q.wall_code         <= tile_q;
			out_q.hit_vertical_side <= xside_q;
			out_q.hit_x             <= hit_x_q;
			out_q.hit_y             <= hit_y_q;
			out_q.found             <= found_q;
			out_q.strip_top         <= ds_q;
			out_q.strip_bottom      <= de_q;
			out_q.red               <= red_q;
			out_q.green             <= green_q;
			out_q.blue              <= blue_q;
		end
	end

	assign status.clear_last = (clr_addr_q == '1);
	assign status.div_done   = div_done;
	assign status.wall       = oob || (rd_data_q != '0);
	assign status.steps_done = (cnt_q == SW'(MAX_STEPS));
	assign status.out_free   = !out_valid_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`include "grid_ray_cast_column_defines.svh"

	`GRC_CHECK_IMP(a_no_overwrite, cmd.out_load, !out_valid_q, "result overwritten while pending")
	`GRC_CHECK_IMP(a_step_bound, cmd.step, cnt_q < SW'(MAX_STEPS), "grid walk past step limit")
	`GRC_CHECK_NXT(a_div_latency, cmd.div_start, !div_done, "divider finished too early")

endmodule
`default_nettype wire
